@@ hw/rtl/psim_pkg.sv @@
// Shared types and constants of the pose similarity point transform.
// Holds the sequencer state type, the micro-op ROM and the CORDIC arctangent table.
// Depends on nothing; the files that use it refer to it by scoped names.
`default_nettype none

package psim_pkg;

    localparam int SCALE_BITS   = 16;
    localparam int TRIG_BITS    = 32;
    localparam int ACC_BITS     = 33;
    localparam int MUL_BITS     = 33;
    localparam int PROD_BITS    = 2 * MUL_BITS;
    localparam int PERSP_BITS   = 32;
    localparam int CFG_IDX_BITS = 3;
    localparam int DIM          = 3;
    localparam int NPERSP       = 4;
    localparam int MAT_ENTRIES  = DIM * DIM;

    localparam logic signed [33:0] CORDIC_K = 34'sd652032874;
    localparam logic signed [31:0] ONE_Q24  = 32'sh0100_0000;
    localparam logic signed [31:0] PERSP_W_RESET = 32'sh0001_0000;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_THREE_D = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PERSP_X = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PERSP_Y = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PERSP_Z = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PERSP_W = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TRIG,
        S_TRIG_WAIT,
        S_POSE_MUL,
        S_POSE_APPLY,
        S_PT_MUL,
        S_PT_ACC,
        S_DIV_START,
        S_DIV_WAIT,
        S_OUT
    } t_state;

    typedef enum logic [3:0] {
        U_END,
        U_SET,
        U_SETNEG,
        U_LOAD,
        U_ADD,
        U_SUB,
        U_SYSP,
        U_CYSP,
        U_ENTRY
    } t_uop_kind;

    typedef enum logic [2:0] {
        SRC_SY,
        SRC_CY,
        SRC_SP,
        SRC_CP,
        SRC_SR,
        SRC_CR,
        SRC_SYSP,
        SRC_CYSP
    } t_src;

    typedef struct packed {
        t_uop_kind   kind;
        t_src        a;
        t_src        b;
        logic [3:0]  dst;
    } t_uop;

    function automatic t_uop mk(input t_uop_kind k, input t_src a, input t_src b,
                                input logic [3:0] d);
        t_uop u;
        u.kind = k;
        u.a    = a;
        u.b    = b;
        u.dst  = d;
        return u;
    endfunction

    // Matrix build program: 2D uses yaw only, 3D the yaw-pitch-roll product.
    function automatic t_uop uop_rom(input logic three_d, input logic [4:0] step);
        t_uop u;
        u = mk(U_END, SRC_SY, SRC_SY, 4'd0);
        if (!three_d) begin
            case (step)
                5'd0:    u = mk(U_SET,    SRC_CY, SRC_CY, 4'd0);
                5'd1:    u = mk(U_ENTRY,  SRC_CY, SRC_CY, 4'd0);
                5'd2:    u = mk(U_ENTRY,  SRC_CY, SRC_CY, 4'd4);
                5'd3:    u = mk(U_SET,    SRC_SY, SRC_SY, 4'd0);
                5'd4:    u = mk(U_ENTRY,  SRC_SY, SRC_SY, 4'd1);
                5'd5:    u = mk(U_SETNEG, SRC_SY, SRC_SY, 4'd0);
                5'd6:    u = mk(U_ENTRY,  SRC_SY, SRC_SY, 4'd3);
                default: u = mk(U_END,    SRC_SY, SRC_SY, 4'd0);
            endcase
        end else begin
            case (step)
                5'd0:    u = mk(U_SYSP,   SRC_SY,   SRC_SP, 4'd0);
                5'd1:    u = mk(U_CYSP,   SRC_CY,   SRC_SP, 4'd0);
                5'd2:    u = mk(U_LOAD,   SRC_CP,   SRC_CR, 4'd0);
                5'd3:    u = mk(U_ENTRY,  SRC_SY,   SRC_SY, 4'd0);
                5'd4:    u = mk(U_LOAD,   SRC_CP,   SRC_SR, 4'd0);
                5'd5:    u = mk(U_ENTRY,  SRC_SY,   SRC_SY, 4'd1);
                5'd6:    u = mk(U_SETNEG, SRC_SP,   SRC_SP, 4'd0);
                5'd7:    u = mk(U_ENTRY,  SRC_SY,   SRC_SY, 4'd2);
                5'd8:    u = mk(U_LOAD,   SRC_SYSP, SRC_CR, 4'd0);
                5'd9:    u = mk(U_SUB,    SRC_CY,   SRC_SR, 4'd0);
                5'd10:   u = mk(U_ENTRY,  SRC_SY,   SRC_SY, 4'd3);
                5'd11:   u = mk(U_LOAD,   SRC_SYSP, SRC_SR, 4'd0);
                5'd12:   u = mk(U_ADD,    SRC_CY,   SRC_CR, 4'd0);
                5'd13:   u = mk(U_ENTRY,  SRC_SY,   SRC_SY, 4'd4);
                5'd14:   u = mk(U_LOAD,   SRC_SY,   SRC_CP, 4'd0);
                5'd15:   u = mk(U_ENTRY,  SRC_SY,   SRC_SY, 4'd5);
                5'd16:   u = mk(U_LOAD,   SRC_CYSP, SRC_CR, 4'd0);
                5'd17:   u = mk(U_ADD,    SRC_SY,   SRC_SR, 4'd0);
                5'd18:   u = mk(U_ENTRY,  SRC_SY,   SRC_SY, 4'd6);
                5'd19:   u = mk(U_LOAD,   SRC_CYSP, SRC_SR, 4'd0);
                5'd20:   u = mk(U_SUB,    SRC_SY,   SRC_CR, 4'd0);
                5'd21:   u = mk(U_ENTRY,  SRC_SY,   SRC_SY, 4'd7);
                5'd22:   u = mk(U_LOAD,   SRC_CY,   SRC_CP, 4'd0);
                5'd23:   u = mk(U_ENTRY,  SRC_SY,   SRC_SY, 4'd8);
                default: u = mk(U_END,    SRC_SY,   SRC_SY, 4'd0);
            endcase
        end
        return u;
    endfunction

    // arctan(2^-i) with a full turn of 2^32
    function automatic logic [31:0] atan_q32(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:    v = 32'h2000_0000;
            5'd1:    v = 32'h12E4_051E;
            5'd2:    v = 32'h09FB_385B;
            5'd3:    v = 32'h0511_11D4;
            5'd4:    v = 32'h028B_0D43;
            5'd5:    v = 32'h0145_D7E1;
            5'd6:    v = 32'h00A2_F61E;
            5'd7:    v = 32'h0051_7C55;
            5'd8:    v = 32'h0028_BE53;
            5'd9:    v = 32'h0014_5F2F;
            5'd10:   v = 32'h000A_2F98;
            5'd11:   v = 32'h0005_17CC;
            5'd12:   v = 32'h0002_8BE6;
            5'd13:   v = 32'h0001_45F3;
            5'd14:   v = 32'h0000_A2FA;
            5'd15:   v = 32'h0000_517D;
            5'd16:   v = 32'h0000_28BE;
            5'd17:   v = 32'h0000_145F;
            5'd18:   v = 32'h0000_0A30;
            5'd19:   v = 32'h0000_0518;
            5'd20:   v = 32'h0000_028C;
            5'd21:   v = 32'h0000_0146;
            5'd22:   v = 32'h0000_00A3;
            5'd23:   v = 32'h0000_0051;
            default: v = 32'h0000_0000;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/psim_cordic.sv @@
// Iterative rotation-mode CORDIC giving sine and cosine in Q2.30.
// One micro-rotation per cycle; uses the arctangent table of psim_pkg.
`default_nettype none

module psim_cordic #(
    parameter int ANGLE_BITS      = 16,
    parameter int TRIG_ITERATIONS = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire logic [ANGLE_BITS-1:0]  i_angle,
    output logic                        o_done,
    output logic signed [31:0]          o_sin,
    output logic signed [31:0]          o_cos
);

    localparam int IW = $clog2(TRIG_ITERATIONS + 1);

    logic [31:0]        w_a;
    logic               w_neg;
    logic signed [31:0] w_z0;
    logic signed [33:0] w_dx, w_dy, w_atan;

    logic               r_busy, r_done, r_neg;
    logic [IW-1:0]      r_iter;
    logic signed [33:0] r_x, r_y, r_z;

    // angles in the left half-plane turn by half a turn, result negated
    assign w_a    = {i_angle, {(32 - ANGLE_BITS){1'b0}}};
    assign w_neg  = (w_a[31:30] == 2'b01) || (w_a[31:30] == 2'b10);
    assign w_z0   = {w_a[31] ^ w_neg, w_a[30:0]};
    assign w_dx   = r_y >>> r_iter;
    assign w_dy   = r_x >>> r_iter;
    assign w_atan = {2'b00, psim_pkg::atan_q32(5'(r_iter))};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_iter == IW'(TRIG_ITERATIONS - 1))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= psim_pkg::CORDIC_K;
            r_y    <= '0;
            r_z    <= 34'(w_z0);
            r_neg  <= w_neg;
            r_iter <= '0;
        end else if (r_busy) begin
            if (!r_z[33]) begin
                r_x <= r_x - w_dx;
                r_y <= r_y + w_dy;
                r_z <= r_z - w_atan;
            end else begin
                r_x <= r_x + w_dx;
                r_y <= r_y - w_dy;
                r_z <= r_z + w_atan;
            end
            r_iter <= r_iter + 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_sin  = r_neg ? 32'(-r_y) : 32'(r_y);
    assign o_cos  = r_neg ? 32'(-r_x) : 32'(r_x);

endmodule

`default_nettype wire

@@ hw/rtl/psim_div.sv @@
// Restoring signed divider, one quotient bit per cycle, with saturation.
// Truncates toward zero; zero divisor: flag and signed limit, 0 for 0/0.
`default_nettype none

module psim_div #(
    parameter int COORD_BITS = 24,
    parameter int NUM_BITS   = 58
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic signed [NUM_BITS-1:0]   i_num,
    input  wire logic signed [NUM_BITS-1:0]   i_den,
    output logic                              o_done,
    output logic                              o_zero,
    output logic signed [COORD_BITS-1:0]      o_quo
);

    localparam int DW = NUM_BITS + COORD_BITS;
    localparam int CW = $clog2(COORD_BITS + 1);
    localparam logic [COORD_BITS-1:0] MAXV = {1'b0, {(COORD_BITS - 1){1'b1}}};
    localparam logic [COORD_BITS-1:0] MINV = {1'b1, {(COORD_BITS - 1){1'b0}}};

    logic [NUM_BITS-1:0]   w_nmag, w_dmag;
    logic                  w_fit;

    logic                  r_busy, r_done;
    logic [CW-1:0]         r_cnt;
    logic [NUM_BITS-1:0]   r_rem;
    logic [DW-1:0]         r_den;
    logic [COORD_BITS-1:0] r_quo;
    logic                  r_neg, r_ovf, r_zero, r_upos, r_uneg;

    assign w_nmag = i_num[NUM_BITS-1] ? NUM_BITS'(-i_num) : NUM_BITS'(i_num);
    assign w_dmag = i_den[NUM_BITS-1] ? NUM_BITS'(-i_den) : NUM_BITS'(i_den);
    assign w_fit  = DW'(r_rem) >= r_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= (i_den != '0);
                r_done <= (i_den == '0);
            end else if (r_busy && (r_cnt == CW'(COORD_BITS))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_zero <= (i_den == '0);
            r_upos <= !i_num[NUM_BITS-1] && (i_num != '0);
            r_uneg <= i_num[NUM_BITS-1];
            r_neg  <= i_num[NUM_BITS-1] ^ i_den[NUM_BITS-1];
            r_rem  <= w_nmag;
            r_den  <= {w_dmag, {COORD_BITS{1'b0}}};
            r_quo  <= '0;
            r_ovf  <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            // first pass only checks that the quotient fits
            if (r_cnt == '0) begin
                r_ovf <= w_fit;
            end else if (w_fit) begin
                r_rem <= r_rem - r_den[NUM_BITS-1:0];
                r_quo <= {r_quo[COORD_BITS-2:0], 1'b1};
            end else begin
                r_quo <= {r_quo[COORD_BITS-2:0], 1'b0};
            end
            r_den <= r_den >> 1;
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_comb begin
        if (r_zero) begin
            o_quo = r_upos ? MAXV : (r_uneg ? MINV : '0);
        end else if (r_ovf) begin
            o_quo = r_neg ? MINV : MAXV;
        end else if (!r_neg) begin
            o_quo = r_quo[COORD_BITS-1] ? MAXV : r_quo;
        end else begin
            o_quo = (r_quo > MINV) ? MINV : COORD_BITS'(-r_quo);
        end
    end

    assign o_done = r_done;
    assign o_zero = r_zero;

endmodule

`default_nettype wire

@@ hw/rtl/pose_similarity_point_transform.sv @@
// Pose similarity point transform. A pose word (action 0) loads yaw, pitch,
// roll, a Q4.12 scale and a Q16.8 translation; the block turns the angles
// into sine and cosine with one iterative CORDIC and builds a Q8.24 scaled
// rotation matrix with one shared 33x33 multiplier. A point word (action 1)
// is multiplied by that matrix, the translation is added, and each coordinate
// is divided by w = persp_x*x + persp_y*y (+ persp_z*z) + persp_w in a
// bit-serial divider; quotients saturate to Q16.8 and a zero w raises
// div_zero. Config register three_d picks 2D (yaw only, z output zero) or 3D.
// One word is in flight at a time; o_in_stall is high until it is done.
// A pose's time is set by the CORDIC loop and by the matrix micro-ops on the
// shared multiplier; a point's time is dominated by the divider loop, and a
// zero w shortens each divide. A finished result sits in the output register,
// so the next word is taken while the result waits. Config writes are always
// ready and are meant for idle periods only.
`default_nettype none

module pose_similarity_point_transform #(
    parameter int COORD_BITS      = 24,
    parameter int ANGLE_BITS      = 16,
    parameter int TRIG_ITERATIONS = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // item input
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_stall,
    input  wire logic                                  i_action,
    input  wire logic signed [ANGLE_BITS-1:0]          i_yaw,
    input  wire logic signed [ANGLE_BITS-1:0]          i_pitch,
    input  wire logic signed [ANGLE_BITS-1:0]          i_roll,
    input  wire logic signed [psim_pkg::SCALE_BITS-1:0] i_scale,
    input  wire logic signed [COORD_BITS-1:0]          i_shift_x,
    input  wire logic signed [COORD_BITS-1:0]          i_shift_y,
    input  wire logic signed [COORD_BITS-1:0]          i_shift_z,
    input  wire logic signed [COORD_BITS-1:0]          i_point_x,
    input  wire logic signed [COORD_BITS-1:0]          i_point_y,
    input  wire logic signed [COORD_BITS-1:0]          i_point_z,
    // result output
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_stall,
    output logic signed [COORD_BITS-1:0]               o_out_x,
    output logic signed [COORD_BITS-1:0]               o_out_y,
    output logic signed [COORD_BITS-1:0]               o_out_z,
    output logic                                       o_div_zero,
    // configuration writes
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [psim_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  wire logic [31:0]                           i_cfg_data
);

    // accumulator width: three Q8.24 x Q16.8 products plus the shifted translation
    localparam int UW = COORD_BITS + 34;
    localparam int MB = psim_pkg::MUL_BITS;
    localparam int PB = psim_pkg::PROD_BITS;

    psim_pkg::t_state r_state, n_state;
    psim_pkg::t_uop   w_uop;

    // configuration and persistent state
    logic                     r_three_d;
    logic signed [31:0]       r_persp [0:psim_pkg::NPERSP-1];
    logic signed [31:0]       r_m     [0:psim_pkg::MAT_ENTRIES-1];
    logic signed [COORD_BITS-1:0] r_t [0:psim_pkg::DIM-1];

    // working registers
    logic [ANGLE_BITS-1:0]    r_ang   [0:psim_pkg::DIM-1];
    logic signed [15:0]       r_scale;
    logic signed [COORD_BITS-1:0] r_p [0:psim_pkg::DIM-1];
    logic signed [31:0]       r_sin   [0:psim_pkg::DIM-1];
    logic signed [31:0]       r_cos   [0:psim_pkg::DIM-1];
    logic signed [31:0]       r_sysp, r_cysp;
    logic signed [psim_pkg::ACC_BITS-1:0] r_acc;
    logic [4:0]               r_step;
    logic signed [PB-1:0]     r_prod;
    logic [1:0]               r_row, r_col, r_tidx;
    logic signed [UW-1:0]     r_u     [0:psim_pkg::DIM-1];
    logic signed [UW-1:0]     r_w;
    logic signed [COORD_BITS-1:0] r_q [0:psim_pkg::DIM-1];
    logic                     r_dz;

    // output register
    logic                     r_out_valid, r_out_dz;
    logic signed [COORD_BITS-1:0] r_out_x, r_out_y, r_out_z;

    logic                     w_idle, w_in_acc, w_out_load;
    logic                     w_cordic_start, w_div_start;
    logic [1:0]               w_last, w_tlast;
    logic [3:0]               w_midx;
    logic signed [31:0]       w_src_a, w_src_b;
    logic signed [MB-1:0]     w_mul_a, w_mul_b;
    logic signed [PB-1:0]     w_prod, w_rnd30, w_rnd18;
    logic signed [psim_pkg::ACC_BITS-1:0] w_m30;
    logic signed [47:0]       w_e;
    logic signed [31:0]       w_ent;
    logic signed [UW-1:0]     w_pterm;

    logic                     w_cdone, w_ddone, w_dzero;
    logic signed [31:0]       w_csin, w_ccos;
    logic signed [COORD_BITS-1:0] w_dquo;

    assign w_idle     = (r_state == psim_pkg::S_IDLE);
    assign w_in_acc   = i_in_valid && w_idle;
    assign o_in_stall = !w_idle;
    assign o_cfg_ready = 1'b1;

    assign w_last  = r_three_d ? 2'd2 : 2'd1;
    assign w_tlast = r_three_d ? 2'd2 : 2'd0;
    assign w_uop   = psim_pkg::uop_rom(r_three_d, r_step);
    assign w_midx  = 4'(r_row) * 4'd3 + 4'(r_col);

    // trig operand selection for the matrix program
    always_comb begin
        case (w_uop.a)
            psim_pkg::SRC_SY:   w_src_a = r_sin[0];
            psim_pkg::SRC_CY:   w_src_a = r_cos[0];
            psim_pkg::SRC_SP:   w_src_a = r_sin[1];
            psim_pkg::SRC_CP:   w_src_a = r_cos[1];
            psim_pkg::SRC_SR:   w_src_a = r_sin[2];
            psim_pkg::SRC_CR:   w_src_a = r_cos[2];
            psim_pkg::SRC_SYSP: w_src_a = r_sysp;
            psim_pkg::SRC_CYSP: w_src_a = r_cysp;
            default:            w_src_a = '0;
        endcase
        case (w_uop.b)
            psim_pkg::SRC_SY:   w_src_b = r_sin[0];
            psim_pkg::SRC_CY:   w_src_b = r_cos[0];
            psim_pkg::SRC_SP:   w_src_b = r_sin[1];
            psim_pkg::SRC_CP:   w_src_b = r_cos[1];
            psim_pkg::SRC_SR:   w_src_b = r_sin[2];
            psim_pkg::SRC_CR:   w_src_b = r_cos[2];
            psim_pkg::SRC_SYSP: w_src_b = r_sysp;
            psim_pkg::SRC_CYSP: w_src_b = r_cysp;
            default:            w_src_b = '0;
        endcase
    end

    // shared multiplier operands
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            psim_pkg::S_POSE_MUL: begin
                if (w_uop.kind == psim_pkg::U_ENTRY) begin
                    w_mul_a = r_acc;
                    w_mul_b = MB'(r_scale);
                end else begin
                    w_mul_a = MB'(w_src_a);
                    w_mul_b = MB'(w_src_b);
                end
            end
            psim_pkg::S_PT_MUL: begin
                w_mul_a = (r_row == 2'd3) ? MB'(r_persp[r_col]) : MB'(r_m[w_midx]);
                w_mul_b = MB'(r_p[r_col]);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod  = w_mul_a * w_mul_b;

    // round-half-up products, floor shifts
    assign w_rnd30 = r_prod + (PB'(1) <<< 29);
    assign w_rnd18 = r_prod + (PB'(1) <<< 17);
    assign w_m30   = w_rnd30[62:30];
    assign w_e     = w_rnd18[65:18];
    assign w_pterm = r_prod[UW-1:0];

    // saturate a matrix entry to 32 bits
    always_comb begin
        if (!w_e[47] && (|w_e[46:31])) begin
            w_ent = 32'sh7FFF_FFFF;
        end else if (w_e[47] && !(&w_e[46:31])) begin
            w_ent = 32'sh8000_0000;
        end else begin
            w_ent = w_e[31:0];
        end
    end

    assign w_out_load = (r_state == psim_pkg::S_OUT) && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= psim_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        w_cordic_start = 1'b0;
        w_div_start    = 1'b0;
        case (r_state)
            psim_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    n_state = i_action ? psim_pkg::S_PT_MUL : psim_pkg::S_TRIG;
                end
            end
            psim_pkg::S_TRIG: begin
                w_cordic_start = 1'b1;
                n_state        = psim_pkg::S_TRIG_WAIT;
            end
            psim_pkg::S_TRIG_WAIT: begin
                if (w_cdone) begin
                    n_state = (r_tidx == w_tlast) ? psim_pkg::S_POSE_MUL : psim_pkg::S_TRIG;
                end
            end
            psim_pkg::S_POSE_MUL: begin
                n_state = (w_uop.kind == psim_pkg::U_END) ? psim_pkg::S_IDLE
                                                          : psim_pkg::S_POSE_APPLY;
            end
            psim_pkg::S_POSE_APPLY: begin
                n_state = psim_pkg::S_POSE_MUL;
            end
            psim_pkg::S_PT_MUL: begin
                n_state = psim_pkg::S_PT_ACC;
            end
            psim_pkg::S_PT_ACC: begin
                if ((r_row == 2'd3) && (r_col == w_last)) begin
                    n_state = psim_pkg::S_DIV_START;
                end else begin
                    n_state = psim_pkg::S_PT_MUL;
                end
            end
            psim_pkg::S_DIV_START: begin
                w_div_start = 1'b1;
                n_state     = psim_pkg::S_DIV_WAIT;
            end
            psim_pkg::S_DIV_WAIT: begin
                if (w_ddone) begin
                    n_state = (r_row == w_last) ? psim_pkg::S_OUT : psim_pkg::S_DIV_START;
                end
            end
            psim_pkg::S_OUT: begin
                if (w_out_load) begin
                    n_state = psim_pkg::S_IDLE;
                end
            end
            default: n_state = psim_pkg::S_IDLE;
        endcase
    end

    // configuration, stored pose and output handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_three_d   <= 1'b1;
            r_persp[0]  <= '0;
            r_persp[1]  <= '0;
            r_persp[2]  <= '0;
            r_persp[3]  <= psim_pkg::PERSP_W_RESET;
            for (int i = 0; i < psim_pkg::MAT_ENTRIES; i++) begin
                r_m[i] <= (i % 4 == 0) ? psim_pkg::ONE_Q24 : '0;
            end
            for (int i = 0; i < psim_pkg::DIM; i++) begin
                r_t[i] <= '0;
            end
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    psim_pkg::CFG_THREE_D: r_three_d  <= i_cfg_data[0];
                    psim_pkg::CFG_PERSP_X: r_persp[0] <= i_cfg_data;
                    psim_pkg::CFG_PERSP_Y: r_persp[1] <= i_cfg_data;
                    psim_pkg::CFG_PERSP_Z: r_persp[2] <= i_cfg_data;
                    psim_pkg::CFG_PERSP_W: r_persp[3] <= i_cfg_data;
                    default: ;
                endcase
            end
            // a pose takes its translation now; 2D clears the matrix first
            if (w_in_acc && !i_action) begin
                r_t[0] <= i_shift_x;
                r_t[1] <= i_shift_y;
                r_t[2] <= r_three_d ? i_shift_z : '0;
                if (!r_three_d) begin
                    for (int i = 0; i < psim_pkg::MAT_ENTRIES; i++) begin
                        r_m[i] <= '0;
                    end
                end
            end
            if ((r_state == psim_pkg::S_POSE_APPLY) && (w_uop.kind == psim_pkg::U_ENTRY)) begin
                r_m[w_uop.dst] <= w_ent;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            psim_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    r_ang[0] <= i_yaw;
                    r_ang[1] <= i_pitch;
                    r_ang[2] <= i_roll;
                    r_scale  <= i_scale;
                    r_tidx   <= '0;
                    r_step   <= '0;
                    r_p[0]   <= i_point_x;
                    r_p[1]   <= i_point_y;
                    r_p[2]   <= r_three_d ? i_point_z : '0;
                    r_u[0]   <= UW'(r_t[0]) <<< 24;
                    r_u[1]   <= UW'(r_t[1]) <<< 24;
                    r_u[2]   <= r_three_d ? (UW'(r_t[2]) <<< 24) : '0;
                    r_w      <= UW'(r_persp[3]) <<< 8;
                    r_row    <= '0;
                    r_col    <= '0;
                    r_dz     <= 1'b0;
                end
            end
            psim_pkg::S_TRIG_WAIT: begin
                if (w_cdone) begin
                    r_sin[r_tidx] <= w_csin;
                    r_cos[r_tidx] <= w_ccos;
                    r_tidx        <= r_tidx + 1'b1;
                end
            end
            psim_pkg::S_POSE_MUL: begin
                r_prod <= w_prod;
            end
            psim_pkg::S_POSE_APPLY: begin
                case (w_uop.kind)
                    psim_pkg::U_SET:    r_acc  <= psim_pkg::ACC_BITS'(w_src_a);
                    psim_pkg::U_SETNEG: r_acc  <= -psim_pkg::ACC_BITS'(w_src_a);
                    psim_pkg::U_LOAD:   r_acc  <= w_m30;
                    psim_pkg::U_ADD:    r_acc  <= r_acc + w_m30;
                    psim_pkg::U_SUB:    r_acc  <= r_acc - w_m30;
                    psim_pkg::U_SYSP:   r_sysp <= w_m30[31:0];
                    psim_pkg::U_CYSP:   r_cysp <= w_m30[31:0];
                    default: ;
                endcase
                r_step <= r_step + 1'b1;
            end
            psim_pkg::S_PT_MUL: begin
                r_prod <= w_prod;
            end
            psim_pkg::S_PT_ACC: begin
                if (r_row == 2'd3) begin
                    r_w <= r_w + w_pterm;
                end else begin
                    r_u[r_row] <= r_u[r_row] + w_pterm;
                end
                // walk columns, then rows; the w row comes last
                if (r_col == w_last) begin
                    r_col <= '0;
                    if (r_row == 2'd3) begin
                        r_row <= '0;
                    end else if (r_row == w_last) begin
                        r_row <= 2'd3;
                    end else begin
                        r_row <= r_row + 1'b1;
                    end
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
            psim_pkg::S_DIV_WAIT: begin
                if (w_ddone) begin
                    r_q[r_row] <= w_dquo;
                    r_dz       <= r_dz | w_dzero;
                    r_row      <= r_row + 1'b1;
                end
            end
            psim_pkg::S_OUT: begin
                if (w_out_load) begin
                    r_out_x  <= r_q[0];
                    r_out_y  <= r_q[1];
                    r_out_z  <= r_three_d ? r_q[2] : '0;
                    r_out_dz <= r_dz;
                end
            end
            default: ;
        endcase
    end

    psim_cordic #(
        .ANGLE_BITS      (ANGLE_BITS),
        .TRIG_ITERATIONS (TRIG_ITERATIONS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cordic_start),
        .i_angle (r_ang[r_tidx]),
        .o_done  (w_cdone),
        .o_sin   (w_csin),
        .o_cos   (w_ccos)
    );

    psim_div #(
        .COORD_BITS (COORD_BITS),
        .NUM_BITS   (UW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_u[r_row]),
        .i_den   (r_w),
        .o_done  (w_ddone),
        .o_zero  (w_dzero),
        .o_quo   (w_dquo)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_x     = r_out_x;
    assign o_out_y     = r_out_y;
    assign o_out_z     = r_out_z;
    assign o_div_zero  = r_out_dz;

endmodule

`default_nettype wire

@@ hw/rtl/psim_checker.sv @@
// Port-level checks for the pose similarity point transform.
// Bound to the top level below; uses only its ports.
`default_nettype none

module psim_checker #(
    parameter int COORD_BITS = 24
) (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_in_valid,
    input wire logic                         o_in_stall,
    input wire logic                         o_out_valid,
    input wire logic                         i_out_stall,
    input wire logic signed [COORD_BITS-1:0] o_out_x,
    input wire logic signed [COORD_BITS-1:0] o_out_y,
    input wire logic                         o_div_zero
);

    localparam logic [COORD_BITS-1:0] MAXV = {1'b0, {(COORD_BITS - 1){1'b1}}};
    localparam logic [COORD_BITS-1:0] MINV = {1'b1, {(COORD_BITS - 1){1'b0}}};

    // hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_out_x) && $stable(o_out_y)))
        else $error("stalled result word changed");

    // an accepted word keeps the block busy for at least the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken again right after accept");

    // a new result only appears from a word in progress
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without a word in progress");

    // a zero w gives only limits or zero
    a_div_zero_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_div_zero) |->
            ((o_out_x == MAXV) || (o_out_x == MINV) || (o_out_x == '0)) &&
            ((o_out_y == MAXV) || (o_out_y == MINV) || (o_out_y == '0)))
        else $error("div_zero result not saturated");

endmodule

bind pose_similarity_point_transform psim_checker #(
    .COORD_BITS (COORD_BITS)
) u_psim_checker (.*);

`default_nettype wire

@@ sim/tb_pose_similarity_point_transform.sv @@
// Self-checking bench for the pose similarity point transform.
// Predicts every point result from its own fixed-point model of the block.
// Depends on hw/rtl/psim_pkg.sv and hw/rtl/pose_similarity_point_transform.sv.
`default_nettype none

module tb_pose_similarity_point_transform;

    localparam int CB = 24;
    localparam int AB = 16;
    localparam int TRIG_ITERS = 16;
    localparam longint CYCLE_LIMIT = 400000;

    // One point result as the block presents it.
    typedef struct packed {
        logic signed [CB-1:0] x;
        logic signed [CB-1:0] y;
        logic signed [CB-1:0] z;
        logic                 dz;
    } point_res_t;

    // One input word.
    typedef struct packed {
        logic                 action;
        logic signed [AB-1:0] yaw;
        logic signed [AB-1:0] pitch;
        logic signed [AB-1:0] roll;
        logic signed [15:0]   scale;
        logic signed [CB-1:0] sx;
        logic signed [CB-1:0] sy;
        logic signed [CB-1:0] sz;
        logic signed [CB-1:0] px;
        logic signed [CB-1:0] py;
        logic signed [CB-1:0] pz;
    } word_t;

    // Holds the transform state and the queue of pending point results.
    class transform_scoreboard;
        bit          mode_3d;
        longint      persp[4];
        longint      mat[9];
        longint      shift[3];
        point_res_t  pending[$];
        int          errors;

        function void reset_state();
            mode_3d = 1;
            persp[0] = 0; persp[1] = 0; persp[2] = 0; persp[3] = 65536;
            for (int i = 0; i < 9; i++) mat[i] = (i % 4 == 0) ? 64'sd16777216 : 0;
            for (int i = 0; i < 3; i++) shift[i] = 0;
            pending.delete();
            errors = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] data);
            case (idx)
                psim_pkg::CFG_THREE_D: mode_3d = data[0];
                psim_pkg::CFG_PERSP_X: persp[0] = longint'(signed'(data));
                psim_pkg::CFG_PERSP_Y: persp[1] = longint'(signed'(data));
                psim_pkg::CFG_PERSP_Z: persp[2] = longint'(signed'(data));
                psim_pkg::CFG_PERSP_W: persp[3] = longint'(signed'(data));
                default: ;
            endcase
        endfunction

        function longint floor_shr(longint v, int n);
            return v >>> n;
        endfunction

        function longint clamp(longint v, int bits);
            longint hi, lo;
            hi = (64'sd1 <<< (bits - 1)) - 1;
            lo = -hi - 1;
            return v > hi ? hi : (v < lo ? lo : v);
        endfunction

        function void trig(logic [AB-1:0] ang, output longint s, output longint c);
            logic [31:0] a;
            bit          flip;
            longint      x, y, z, dx, dy, at;
            a = {ang, {(32 - AB){1'b0}}};
            flip = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
            if (flip) a = a + 32'h8000_0000;
            x = 652032874; y = 0; z = longint'(signed'(a));
            for (int i = 0; i < TRIG_ITERS; i++) begin
                dx = floor_shr(y, i);
                dy = floor_shr(x, i);
                at = longint'(psim_pkg::atan_q32(5'(i)));
                if (z >= 0) begin
                    x -= dx; y += dy; z -= at;
                end else begin
                    x += dx; y -= dy; z += at;
                end
            end
            s = flip ? -y : y;
            c = flip ? -x : x;
        endfunction

        function longint tmul(longint a, longint b);
            return floor_shr(a * b + (64'sd1 <<< 29), 30);
        endfunction

        function longint ent(longint s, longint t);
            return clamp(floor_shr(s * t + (64'sd1 <<< 17), 18), 32);
        endfunction

        function longint qdiv(longint u, longint w, inout bit dz);
            longint hi;
            hi = (64'sd1 <<< (CB - 1)) - 1;
            if (w == 0) begin
                dz = 1;
                return u > 0 ? hi : (u < 0 ? -hi - 1 : 0);
            end
            return clamp(u / w, CB);
        endfunction

        // Note an accepted word: update the pose or queue a point result.
        function void note_word(word_t w);
            longint s, sy, cy, sp, cp, sr, cr, sysp, cysp, wq;
            longint p[3], u[3];
            int     n;
            bit     dz;
            point_res_t r;
            if (!w.action) begin
                s = w.scale;
                trig(w.yaw, sy, cy);
                shift[0] = w.sx;
                shift[1] = w.sy;
                if (!mode_3d) begin
                    for (int i = 0; i < 9; i++) mat[i] = 0;
                    mat[0] = ent(s, cy); mat[1] = ent(s, sy);
                    mat[3] = ent(s, -sy); mat[4] = ent(s, cy);
                    shift[2] = 0;
                end else begin
                    trig(w.pitch, sp, cp);
                    trig(w.roll, sr, cr);
                    sysp = tmul(sy, sp);
                    cysp = tmul(cy, sp);
                    mat[0] = ent(s, tmul(cp, cr));
                    mat[1] = ent(s, tmul(cp, sr));
                    mat[2] = ent(s, -sp);
                    mat[3] = ent(s, tmul(sysp, cr) - tmul(cy, sr));
                    mat[4] = ent(s, tmul(sysp, sr) + tmul(cy, cr));
                    mat[5] = ent(s, tmul(sy, cp));
                    mat[6] = ent(s, tmul(cysp, cr) + tmul(sy, sr));
                    mat[7] = ent(s, tmul(cysp, sr) - tmul(sy, cr));
                    mat[8] = ent(s, tmul(cy, cp));
                    shift[2] = w.sz;
                end
                return;
            end
            n = mode_3d ? 3 : 2;
            dz = 0;
            p[0] = w.px; p[1] = w.py; p[2] = mode_3d ? longint'(w.pz) : 0;
            wq = persp[0] * p[0] + persp[1] * p[1] + persp[3] * 256;
            if (mode_3d) wq += persp[2] * p[2];
            for (int i = 0; i < 3; i++) begin
                u[i] = 0;
                if (i < n) begin
                    for (int j = 0; j < n; j++) u[i] += mat[i * 3 + j] * p[j];
                    u[i] += shift[i] * 64'sd16777216;
                end
            end
            r.x = CB'(qdiv(u[0], wq, dz));
            r.y = CB'(qdiv(u[1], wq, dz));
            r.z = mode_3d ? CB'(qdiv(u[2], wq, dz)) : '0;
            r.dz = dz;
            pending.push_back(r);
        endfunction

        // Check one result against the oldest pending one.
        function void check_result(point_res_t got);
            point_res_t exp_r;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result x=%0d y=%0d z=%0d dz=%0b",
                         $time, got.x, got.y, got.z, got.dz);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.x !== exp_r.x)
                $display("%0t: out_x expected %0d actual %0d", $time, exp_r.x, got.x);
            if (got.y !== exp_r.y)
                $display("%0t: out_y expected %0d actual %0d", $time, exp_r.y, got.y);
            if (got.z !== exp_r.z)
                $display("%0t: out_z expected %0d actual %0d", $time, exp_r.z, got.z);
            if (got.dz !== exp_r.dz)
                $display("%0t: div_zero expected %0b actual %0b", $time, exp_r.dz, got.dz);
            if (got !== exp_r) errors++;
        endfunction
    endclass

    logic                 clk = 0;
    logic                 rst_n = 0;
    logic                 in_valid = 0;
    logic                 in_stall;
    word_t                drv = '0;
    logic                 out_valid;
    logic                 out_stall = 0;
    point_res_t           res;
    logic                 cfg_valid = 0;
    logic                 cfg_ready;
    logic [2:0]           cfg_index = '0;
    logic [31:0]          cfg_data = '0;

    transform_scoreboard  sb;
    bit                   rx_quiet = 0;   // no idling on the receive side
    bit                   tx_quiet = 0;   // no idling on the send side
    bit                   hold_rx = 0;    // request a long receive hold-off
    longint               cycles = 0;

    always begin
        #2 clk = 1;
        #2 clk = 0;
    end

    pose_similarity_point_transform dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_action(drv.action), .i_yaw(drv.yaw), .i_pitch(drv.pitch), .i_roll(drv.roll),
        .i_scale(drv.scale), .i_shift_x(drv.sx), .i_shift_y(drv.sy), .i_shift_z(drv.sz),
        .i_point_x(drv.px), .i_point_y(drv.py), .i_point_z(drv.pz),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_out_x(res.x), .o_out_y(res.y), .o_out_z(res.z), .o_div_zero(res.dz),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    // Sample results and the scoreboard at the rising edge.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (rst_n && out_valid && !out_stall) sb.check_result(res);
    end

    // Receive side: random stall bursts, plus one long hold-off on request.
    initial begin
        int n;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_rx) begin
                out_stall <= 1;
                repeat (400) @(negedge clk);
                hold_rx = 0;
                out_stall <= 0;
            end else if (!rx_quiet && $urandom_range(0, 7) == 0) begin
                n = $urandom_range(1, 6);
                out_stall <= 1;
                repeat (n) @(negedge clk);
                out_stall <= 0;
            end
        end
    end

    // Timeout watchdog.
    initial begin
        wait (cycles >= CYCLE_LIMIT);
        $display("pose_similarity_point_transform verification failed");
        $finish;
    end

    // Offer one word and hold it until accepted; random gap first.
    // Valid stays high after accept so the next word can follow directly.
    task automatic send_word(word_t w);
        if (!tx_quiet && $urandom_range(0, 5) == 0) begin
            in_valid <= 0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        drv <= w;
        in_valid <= 1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_word(w);
        @(negedge clk);
    endtask

    // Write a register; only called with the block idle.
    task automatic write_cfg(logic [2:0] idx, logic [31:0] data);
        @(negedge clk);
        in_valid <= 0;
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    // Drop valid, wait for every pending result, then let an in-flight pose finish.
    task automatic drain();
        in_valid <= 0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    function automatic logic [CB-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return {1'b0, {(CB - 1){1'b1}}};
            1: return {1'b1, {(CB - 1){1'b0}}};
            2: return CB'($urandom_range(0, 2047)) - CB'(1024);
            default: return CB'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] rand_persp();
        case ($urandom_range(0, 4))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'($urandom_range(0, 512)) - 32'd256;
            default: return $urandom;
        endcase
    endfunction

    function automatic word_t rand_word(bit pt);
        word_t w;
        w.action = pt;
        w.yaw = AB'($urandom); w.pitch = AB'($urandom); w.roll = AB'($urandom);
        w.scale = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                : 16'($urandom_range(0, 16384)) - 16'd8192;
        w.sx = rand_coord(); w.sy = rand_coord(); w.sz = rand_coord();
        w.px = rand_coord(); w.py = rand_coord(); w.pz = rand_coord();
        return w;
    endfunction

    initial begin
        word_t w;
        logic [15:0] angs[8];
        sb = new();
        sb.reset_state();
        repeat (11) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);

        // Directed: points against the identity, quadrant-edge angles, scale extremes.
        w = '0; w.action = 1; w.px = 24'h7fffff; w.py = 24'h800000; w.pz = 24'd256;
        send_word(w);
        angs = '{16'h0000, 16'h4000, 16'h4001, 16'h8000, 16'hbfff, 16'hc000,
                 16'h7fff, 16'hffff};
        for (int i = 0; i < 8; i++) begin
            w = rand_word(0);
            w.yaw = angs[i]; w.pitch = angs[7 - i]; w.roll = angs[(i + 3) % 8];
            w.scale = (i == 0) ? 16'h7fff : (i == 1) ? 16'h8000 : 16'h1000;
            send_word(w);
            w = rand_word(1);
            send_word(w);
        end
        drain();
        // Zero w: a zero point with a zero constant term, and a saturating sum.
        write_cfg(psim_pkg::CFG_PERSP_W, 32'd0);
        w = rand_word(1); w.px = '0; w.py = '0; w.pz = '0;
        send_word(w);
        w = rand_word(1);
        send_word(w);
        drain();
        // Mode switch after a 3D pose, then a 2D pose used in 3D mode.
        write_cfg(psim_pkg::CFG_PERSP_W, 32'h0001_0000);
        write_cfg(psim_pkg::CFG_THREE_D, 32'd0);
        send_word(rand_word(1));
        send_word(rand_word(0));
        drain();
        write_cfg(psim_pkg::CFG_THREE_D, 32'd1);
        send_word(rand_word(1));
        drain();

        // Random phases: each with its own register setting.
        for (int ph = 0; ph < 10; ph++) begin
            write_cfg(psim_pkg::CFG_THREE_D, 32'($urandom_range(0, 1)));
            write_cfg(psim_pkg::CFG_PERSP_X, (ph % 3 == 0) ? 32'd0 : rand_persp());
            write_cfg(psim_pkg::CFG_PERSP_Y, (ph % 3 == 0) ? 32'd0 : rand_persp());
            write_cfg(psim_pkg::CFG_PERSP_Z, (ph % 3 == 0) ? 32'd0 : rand_persp());
            write_cfg(psim_pkg::CFG_PERSP_W,
                      (ph % 3 == 0) ? 32'h0001_0000 : rand_persp());
            if (ph == 7) begin
                rx_quiet = 1;
                tx_quiet = 1;
            end
            if (ph == 3) hold_rx = 1;
            for (int k = 0; k < 48; k++)
                send_word(rand_word($urandom_range(0, 3) != 0));
            // Pause the sender until every result is in.
            drain();
        end

        while (sb.pending.size() != 0) @(negedge clk);
        repeat (50) @(negedge clk);
        if (sb.errors == 0)
            $display("pose_similarity_point_transform verification clean");
        else
            $display("pose_similarity_point_transform verification failed");
        $finish;
    end

endmodule

`default_nettype wire
